FILE: design/q2e_pkg.sv
package q2e_pkg;

  // Number of CORDIC cells in each angle lane.
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_TABLE = 24;

  // Width of the rotation terms, at a scale of 2^28.
  localparam int TW = 36;
  // Width of the CORDIC x and y words.
  localparam int CW = 38;
  // Width of the angle accumulator, in units of 2^-16 degree.
  localparam int AW = 27;
  // Width of the square root remainder and root words.
  localparam int SW = 58;
  // One root bit per cell, for radicands up to 2^56.
  localparam int SQRT_CELLS = 29;

  localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
  localparam logic signed [AW-1:0] DEG180 = AW'(64'sd11796480);
  localparam logic signed [17:0] LIM_FULL = 18'sd23040;
  localparam logic signed [17:0] LIM_HALF = 18'sd11520;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0]        rem;
    logic [SW-1:0]        res;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } sqrt_t;

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
  function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:  v = AW'(2949120);
      5'd1:  v = AW'(1740967);
      5'd2:  v = AW'(919879);
      5'd3:  v = AW'(466945);
      5'd4:  v = AW'(234379);
      5'd5:  v = AW'(117304);
      5'd6:  v = AW'(58666);
      5'd7:  v = AW'(29335);
      5'd8:  v = AW'(14668);
      5'd9:  v = AW'(7334);
      5'd10: v = AW'(3667);
      5'd11: v = AW'(1833);
      5'd12: v = AW'(917);
      5'd13: v = AW'(458);
      5'd14: v = AW'(229);
      5'd15: v = AW'(115);
      5'd16: v = AW'(57);
      5'd17: v = AW'(29);
      5'd18: v = AW'(14);
      5'd19: v = AW'(7);
      5'd20: v = AW'(4);
      5'd21: v = AW'(2);
      5'd22: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up to 1/128 degree and saturate to +-lim; a zero vector gives 0.
  function automatic logic signed [17:0] round_sat(input cordic_t d,
                                                   input logic signed [17:0] lim);
    logic signed [AW-1:0] s;
    logic signed [17:0]   r;
    s = d.acc + AW'(256);
    r = s[AW-1:9];
    if (d.zero) begin
      r = '0;
    end else if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

FILE: design/q2e_sqrt_cell.sv
module q2e_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [5:0]     bit_exp,
  input  logic           valid_in,
  input  q2e_pkg::sqrt_t d_in,
  output logic           valid_out,
  output q2e_pkg::sqrt_t d_out
);
  import q2e_pkg::*;

  logic          valid_r;
  sqrt_t         d_r;
  sqrt_t         d_nxt;
  logic [SW-1:0] bit_v;
  logic [SW-1:0] trial;

  // One restoring step of the digit-by-digit square root.
  always_comb begin
    d_nxt = d_in;
    bit_v = SW'(1) << bit_exp;
    trial = d_in.res + bit_v;
    if (d_in.rem >= trial) begin
      d_nxt.rem = d_in.rem - trial;
      d_nxt.res = (d_in.res >> 1) + bit_v;
    end else begin
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign valid_out = valid_r;
  assign d_out = d_r;

endmodule

FILE: design/q2e_cordic_cell.sv
module q2e_cordic_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       stage_idx,
  input  logic             valid_in,
  input  q2e_pkg::cordic_t d_in,
  output logic             valid_out,
  output q2e_pkg::cordic_t d_out
);
  import q2e_pkg::*;

  logic    valid_r;
  cordic_t d_r;
  cordic_t d_nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // One vectoring micro-rotation toward the x axis.
  always_comb begin
    d_nxt = d_in;
    xs = d_in.x >>> stage_idx;
    ys = d_in.y >>> stage_idx;
    if (!d_in.y[CW-1]) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.acc = d_in.acc + atan_entry(stage_idx);
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.acc = d_in.acc - atan_entry(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign valid_out = valid_r;
  assign d_out = d_r;

endmodule

FILE: design/quaternion_to_euler_angles_core.sv
// Quaternion to roll, pitch and yaw.
// Input channel in_*: one item is a quaternion, in_tdata holds w, x, y, z
// as signed Q2.14 words from the lowest bit up.
// Output channel out_*: one item per input item, out_tdata holds roll,
// pitch and yaw in signed 1/128 degree units.
// The block is a pipeline: three stages form and clamp the rotation terms,
// a row of 29 square root cells gives the cosine of pitch, one stage folds
// the operands into the right half plane, a row of 16 CORDIC cells per angle
// lane resolves the angles, and the output register rounds and saturates.
// One item can be accepted every cycle while out_tready is high.
// The whole pipeline advances together: it moves whenever the output
// register is empty or is being taken, so a stalled receiver holds every
// stage and in_tready falls until the result is taken.
// Reset clears all valid bits; no items are in flight after reset.
module quaternion_to_euler_angles_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // roll_deg[15:0], pitch_deg[30:16], yaw_deg[46:31], bit 47 always 0
  output logic [47:0] out_tdata
);
  import q2e_pkg::*;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage A: products of the quaternion words.
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  logic va_r;
  logic signed [31:0] yy_r, zz_r, xx_r, xy_r, wz_r, wy_r, xz_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xx_r <= qx * qx;
      xy_r <= qx * qy;
      wz_r <= qw * qz;
      wy_r <= qw * qy;
      xz_r <= qx * qz;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
    end
  end

  // Stage B: rotation terms and the clamped sine of pitch.
  logic vb_r;
  logic signed [TW-1:0] t0_r, t1_r, t2_r, t3_r, t4_r;
  logic [28:0] sq_r;
  logic signed [TW-1:0] t2_raw, t2_cl;

  always_comb begin
    t2_raw = (TW'(wy_r) - TW'(xz_r)) <<< 1;
    t2_cl = t2_raw;
    if (t2_raw > ONE_Q28) begin
      t2_cl = ONE_Q28;
    end else if (t2_raw < -ONE_Q28) begin
      t2_cl = -ONE_Q28;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= ONE_Q28 - ((TW'(yy_r) + TW'(zz_r)) <<< 1);
      t1_r <= (TW'(xy_r) + TW'(wz_r)) <<< 1;
      t2_r <= t2_cl;
      t3_r <= (TW'(yz_r) + TW'(wx_r)) <<< 1;
      t4_r <= ONE_Q28 - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
      sq_r <= t2_cl[TW-1] ? 29'(-t2_cl) : 29'(t2_cl);
    end
  end

  // Stage C: radicand 2^56 - s^2 for the cosine of pitch.
  logic  vc_r;
  sqrt_t sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.rem <= (SW'(1) << 56) - (SW'(sq_r) * SW'(sq_r));
      sc_r.res <= '0;
      sc_r.t0 <= t0_r;
      sc_r.t1 <= t1_r;
      sc_r.t2 <= t2_r;
      sc_r.t3 <= t3_r;
      sc_r.t4 <= t4_r;
    end
  end

  // Row of square root cells, one root bit each.
  logic  sv [SQRT_CELLS+1];
  sqrt_t sd [SQRT_CELLS+1];
  assign sv[0] = vc_r;
  assign sd[0] = sc_r;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .bit_exp   (6'(56 - 2 * k)),
      .valid_in  (sv[k]),
      .d_in      (sd[k]),
      .valid_out (sv[k+1]),
      .d_out     (sd[k+1])
    );
  end

  // Fold stage: enter the three lanes in the right half plane.
  function automatic cordic_t fold(input logic signed [TW-1:0] yv,
                                   input logic signed [TW-1:0] xv);
    cordic_t f;
    f.x = CW'(xv);
    f.y = CW'(yv);
    f.acc = '0;
    f.zero = (xv == '0) && (yv == '0);
    if (xv[TW-1]) begin
      f.acc = yv[TW-1] ? -DEG180 : DEG180;
      f.x = -CW'(xv);
      f.y = -CW'(yv);
    end
    return f;
  endfunction

  logic    vf_r;
  cordic_t roll_f_r, pitch_f_r, yaw_f_r;
  sqrt_t   sq_last;
  assign sq_last = sd[SQRT_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= sv[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_f_r <= fold(sq_last.t3, sq_last.t4);
      pitch_f_r <= fold(sq_last.t2, TW'(sq_last.res));
      yaw_f_r <= fold(sq_last.t1, sq_last.t0);
    end
  end

  // CORDIC rows: one lane per angle.
  logic    rv [CORDIC_STAGES+1];
  logic    pv [CORDIC_STAGES+1];
  logic    yv [CORDIC_STAGES+1];
  cordic_t rd [CORDIC_STAGES+1];
  cordic_t pd [CORDIC_STAGES+1];
  cordic_t yd [CORDIC_STAGES+1];
  assign rv[0] = vf_r;
  assign pv[0] = vf_r;
  assign yv[0] = vf_r;
  assign rd[0] = roll_f_r;
  assign pd[0] = pitch_f_r;
  assign yd[0] = yaw_f_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell u_roll (
      .clk (clk), .rst_n (rst_n), .en (en), .stage_idx (5'(i)),
      .valid_in (rv[i]), .d_in (rd[i]), .valid_out (rv[i+1]), .d_out (rd[i+1])
    );
    q2e_cordic_cell u_pitch (
      .clk (clk), .rst_n (rst_n), .en (en), .stage_idx (5'(i)),
      .valid_in (pv[i]), .d_in (pd[i]), .valid_out (pv[i+1]), .d_out (pd[i+1])
    );
    q2e_cordic_cell u_yaw (
      .clk (clk), .rst_n (rst_n), .en (en), .stage_idx (5'(i)),
      .valid_in (yv[i]), .d_in (yd[i]), .valid_out (yv[i+1]), .d_out (yd[i+1])
    );
  end

  // Output register: rounding and saturation.
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic signed [17:0] roll_s, pitch_s, yaw_s;
  logic unused_v;
  assign unused_v = pv[CORDIC_STAGES] ^ yv[CORDIC_STAGES];

  always_comb begin
    roll_s = round_sat(rd[CORDIC_STAGES], LIM_FULL);
    pitch_s = round_sat(pd[CORDIC_STAGES], LIM_HALF);
    yaw_s = round_sat(yd[CORDIC_STAGES], LIM_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {1'b0, yaw_s[15:0], pitch_s[14:0], roll_s[15:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // Checks on the angle ranges and the pipeline control.
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040 &&
                    $signed(out_tdata[15:0]) >= -16'sd23040))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd11520 &&
                    $signed(out_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[46:31]) <= 16'sd23040 &&
                    $signed(out_tdata[46:31]) >= -16'sd23040))
    else $error("yaw out of range");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (rv[CORDIC_STAGES] == pv[CORDIC_STAGES]) && !unused_v)
    else $error("angle lanes out of step");

endmodule
